// ===== src/point_line_segment_distance_assert.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef POINT_LINE_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_LINE_SEGMENT_DISTANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PSD_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PSD_ASSERT_NXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// ===== src/psd_pkg.sv =====
`default_nettype none
package psd_pkg;
	localparam int DIST_W = 25;
	localparam int ADDR_W = 5;
	localparam int QDEPTH = 4;

	localparam logic [1:0] REGION_INTERIOR = 2'd0;
	localparam logic [1:0] REGION_START    = 2'd1;
	localparam logic [1:0] REGION_END      = 2'd2;

	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_START_Z  = 3'd2;
	localparam logic [2:0] REG_END_X    = 3'd3;
	localparam logic [2:0] REG_END_Y    = 3'd4;
	localparam logic [2:0] REG_END_Z    = 3'd5;
	localparam logic [2:0] REG_SEG_MODE = 3'd6;

	typedef struct packed {
		logic [1:0] region;
		logic       degen;
	} psd_tag_t;

	localparam int TAG_W = $bits(psd_tag_t);
endpackage
`default_nettype wire

// ===== src/psd_front.sv =====
`default_nettype none
module psd_front
	import psd_pkg::*;
#(
	parameter int C = 16,
	parameter int S = 2 * C + 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         pt_valid,
	input  wire logic [C-1:0] pt_x,
	input  wire logic [C-1:0] pt_y,
	input  wire logic [C-1:0] pt_z,
	input  wire logic [C-1:0] p0_x,
	input  wire logic [C-1:0] p0_y,
	input  wire logic [C-1:0] p0_z,
	input  wire logic [C-1:0] p1_x,
	input  wire logic [C-1:0] p1_y,
	input  wire logic [C-1:0] p1_z,
	input  wire logic         seg_mode,
	output logic              push,
	output logic [S-1:0]      ent_a,
	output logic [S-1:0]      ent_b,
	output logic [S-1:0]      ent_c1,
	output psd_tag_t          ent_tag
);
	localparam int D  = C + 1;
	localparam int SW = S + 1;

	logic signed [D-1:0] pc [3];
	logic signed [D-1:0] c0 [3];
	logic signed [D-1:0] c1e [3];

	logic                  v_s1, v_s2, v_s3;
	logic signed [D-1:0]   w_s1 [3];
	logic signed [D-1:0]   u_s1 [3];
	logic signed [D-1:0]   d_s1 [3];
	logic signed [2*D-1:0] ww_s2 [3];
	logic signed [2*D-1:0] uu_s2 [3];
	logic signed [2*D-1:0] wv_s2 [3];
	logic signed [2*D-1:0] vv_s2 [3];
	logic [S-1:0]          ww_s3, uu_s3, c2_s3;
	logic signed [SW-1:0]  c1_s3;

	logic             degen, clamp_s, clamp_e;
	logic [SW-1:0]    c1_abs;

	// Sign-extend coordinates to the difference width
	assign pc[0]  = {pt_x[C-1], pt_x};
	assign pc[1]  = {pt_y[C-1], pt_y};
	assign pc[2]  = {pt_z[C-1], pt_z};
	assign c0[0]  = {p0_x[C-1], p0_x};
	assign c0[1]  = {p0_y[C-1], p0_y};
	assign c0[2]  = {p0_z[C-1], p0_z};
	assign c1e[0] = {p1_x[C-1], p1_x};
	assign c1e[1] = {p1_y[C-1], p1_y};
	assign c1e[2] = {p1_z[C-1], p1_z};

	// Track which front stages hold a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Differences, per-axis products, then dot-product sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i]  <= pc[i] - c0[i];
				u_s1[i]  <= pc[i] - c1e[i];
				d_s1[i]  <= c1e[i] - c0[i];
				ww_s2[i] <= w_s1[i] * w_s1[i];
				uu_s2[i] <= u_s1[i] * u_s1[i];
				wv_s2[i] <= w_s1[i] * d_s1[i];
				vv_s2[i] <= d_s1[i] * d_s1[i];
			end
			ww_s3 <= $unsigned(ww_s2[0]) + $unsigned(ww_s2[1]) + $unsigned(ww_s2[2]);
			uu_s3 <= $unsigned(uu_s2[0]) + $unsigned(uu_s2[1]) + $unsigned(uu_s2[2]);
			c2_s3 <= $unsigned(vv_s2[0]) + $unsigned(vv_s2[1]) + $unsigned(vv_s2[2]);
			c1_s3 <= SW'(wv_s2[0]) + SW'(wv_s2[1]) + SW'(wv_s2[2]);
		end
	end

	// Classify: degenerate, clamped to start or end, or interior
	assign degen   = (c2_s3 == '0);
	assign clamp_s = seg_mode && (c1_s3[SW-1] || (c1_s3 == '0));
	assign clamp_e = seg_mode && !clamp_s && ({1'b0, c2_s3} <= $unsigned(c1_s3));
	assign c1_abs  = c1_s3[SW-1] ? SW'(-c1_s3) : $unsigned(c1_s3);

	// Shape the word so the back end always computes (a*b - c1^2) / b
	assign push   = en && v_s3;
	assign ent_a  = (!degen && clamp_e) ? uu_s3 : ww_s3;
	assign ent_b  = degen ? S'(1) : c2_s3;
	assign ent_c1 = (degen || clamp_s || clamp_e) ? '0 : c1_abs[S-1:0];
	always_comb begin
		ent_tag.degen = degen;
		if (degen || clamp_s) begin
			ent_tag.region = REGION_START;
		end else if (clamp_e) begin
			ent_tag.region = REGION_END;
		end else begin
			ent_tag.region = REGION_INTERIOR;
		end
	end
endmodule
`default_nettype wire

// ===== src/psd_queue.sv =====
`default_nettype none
module psd_queue
	import psd_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head,
	output logic              empty,
	output logic              full
);
	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]  mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_pop;

	assign empty  = (count_q == '0);
	assign full   = (count_q == (PW+1)'(QDEPTH));
	assign do_pop = pop && !empty;
	assign head   = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== src/psd_div.sv =====
`default_nettype none
module psd_div
	import psd_pkg::*;
#(
	parameter int S = 34,
	parameter int Q = 50
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [2*S-1:0] in_num,
	input  wire logic [S-1:0]   in_b,
	input  wire psd_tag_t       in_tag,
	output logic                out_valid,
	output logic [Q-1:0]        out_quo,
	output psd_tag_t            out_tag
);
	logic           v_s   [Q+1];
	logic [S-1:0]   rem_s [Q+1];
	logic [Q-1:0]   x_s   [Q+1];
	logic [S-1:0]   b_s   [Q+1];
	psd_tag_t       tag_s [Q+1];

	// Top half of the numerator is the first partial remainder; it is below b
	assign v_s[0]   = in_valid;
	assign rem_s[0] = in_num[2*S-1:S];
	assign x_s[0]   = Q'(in_num[S-1:0]) << (Q - S);
	assign b_s[0]   = in_b;
	assign tag_s[0] = in_tag;

	// One quotient bit per stage: dividend bits shift out, quotient bits shift in
	for (genvar k = 0; k < Q; k++) begin : g_stage
		logic [S:0] t, diff;
		logic       ge;
		assign t    = {rem_s[k], x_s[k][Q-1]};
		assign ge   = (t >= {1'b0, b_s[k]});
		assign diff = t - {1'b0, b_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[S-1:0] : t[S-1:0];
				x_s[k+1]   <= {x_s[k][Q-2:0], ge};
				b_s[k+1]   <= b_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_valid = v_s[Q];
	assign out_quo   = x_s[Q];
	assign out_tag   = tag_s[Q];
endmodule
`default_nettype wire

// ===== src/psd_sqrt.sv =====
`default_nettype none
module psd_sqrt
	import psd_pkg::*;
#(
	parameter int Q = 50,
	parameter int R = 25
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire logic [Q-1:0] in_val,
	input  wire psd_tag_t     in_tag,
	output logic              out_valid,
	output logic [R-1:0]      out_root,
	output psd_tag_t          out_tag
);
	localparam int E = 2 * R;

	logic         v_s    [R+1];
	logic [E-1:0] val_s  [R+1];
	logic [R:0]   rem_s  [R+1];
	logic [R-1:0] root_s [R+1];
	psd_tag_t     tag_s  [R+1];

	assign v_s[0]    = in_valid;
	assign val_s[0]  = E'(in_val);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = in_tag;

	// One root bit per stage: bring down two radicand bits, try {root, 01}
	for (genvar j = 0; j < R; j++) begin : g_stage
		logic [R+2:0] t, trial, diff;
		logic         ge;
		assign t     = {rem_s[j], val_s[j][E-1:E-2]};
		assign trial = {1'b0, root_s[j], 2'b01};
		assign ge    = (t >= trial);
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? diff[R:0] : t[R:0];
				root_s[j+1] <= {root_s[j][R-2:0], ge};
				val_s[j+1]  <= val_s[j] << 2;
				tag_s[j+1]  <= tag_s[j];
			end
		end
	end

	assign out_valid = v_s[R];
	assign out_root  = root_s[R];
	assign out_tag   = tag_s[R];
endmodule
`default_nettype wire

// ===== src/psd_back.sv =====
`default_nettype none
module psd_back
	import psd_pkg::*;
#(
	parameter int C = 16,
	parameter int F = 8,
	parameter int S = 2 * C + 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire logic [S-1:0] in_a,
	input  wire logic [S-1:0] in_b,
	input  wire logic [S-1:0] in_c1,
	input  wire psd_tag_t     in_tag,
	output logic              out_valid,
	output logic [DIST_W-1:0] out_dist,
	output psd_tag_t          out_tag
);
	localparam int L  = (S + 1) / 2;
	localparam int HW = S - L;
	localparam int PW = 2 * S;
	localparam int Q  = S + 2 * F;
	localparam int R  = (Q + 1) / 2;

	logic            v_b1, v_b2, v_b3;
	logic [S+L-1:0]  ab_lo_b1, cc_lo_b1;
	logic [S+HW-1:0] ab_hi_b1, cc_hi_b1;
	logic [S-1:0]    b_b1, b_b2, b_b3;
	psd_tag_t        tag_b1, tag_b2, tag_b3;
	logic [PW-1:0]   ab_b2, cc_b2, num_b3;

	logic            dv;
	logic [Q-1:0]    quo;
	psd_tag_t        dtag;
	logic [R-1:0]    root;

	// Valid bits of the multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
		end else if (en) begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
		end
	end

	// Split products in halves, join them, then form a*b - c1^2
	always_ff @(posedge clk) begin
		if (en) begin
			ab_lo_b1 <= in_a * in_b[L-1:0];
			ab_hi_b1 <= in_a * in_b[S-1:L];
			cc_lo_b1 <= in_c1 * in_c1[L-1:0];
			cc_hi_b1 <= in_c1 * in_c1[S-1:L];
			b_b1     <= in_b;
			tag_b1   <= in_tag;
			ab_b2    <= (PW'(ab_hi_b1) << L) + PW'(ab_lo_b1);
			cc_b2    <= (PW'(cc_hi_b1) << L) + PW'(cc_lo_b1);
			b_b2     <= b_b1;
			tag_b2   <= tag_b1;
			num_b3   <= ab_b2 - cc_b2;
			b_b3     <= b_b2;
			tag_b3   <= tag_b2;
		end
	end

	psd_div #(.S(S), .Q(Q)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_b3),
		.in_num    (num_b3),
		.in_b      (b_b3),
		.in_tag    (tag_b3),
		.out_valid (dv),
		.out_quo   (quo),
		.out_tag   (dtag)
	);

	psd_sqrt #(.Q(Q), .R(R)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv),
		.in_val    (quo),
		.in_tag    (dtag),
		.out_valid (out_valid),
		.out_root  (root),
		.out_tag   (out_tag)
	);

	assign out_dist = DIST_W'(root);
endmodule
`default_nettype wire

// ===== src/point_line_segment_distance.sv =====
// Point to line / segment distance, 3D signed integer coordinates.
// Configuration: APB writes set the endpoints start_x..end_z and segment_mode
// (byte addresses 0..24); write only while no point is in flight.
// Input channel pt_valid/pt_ready carries pt_x, pt_y, pt_z; output channel
// res_valid/res_ready carries distance (Q.FRAC_BITS, floored), region and
// degenerate, one result word per point, in order.
// Throughput: one point per cycle while the queue has room and results are taken.
// The bit-per-stage divider has Q = 2*COORD_BITS + 2 + 2*FRAC_BITS stages and
// the bit-per-stage root pipeline has R = ceil(Q/2) stages.
// A four-word queue separates the classifying front end from the arithmetic
// back end. When res_ready is low the back end holds; the front end keeps
// taking points until the queue fills, then pt_ready drops.
// Reset empties all pipelines, zeroes the endpoints and sets segment_mode.
`default_nettype none
module point_line_segment_distance
	import psd_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_W-1:0]     paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  wire logic                  pt_valid,
	output logic                       pt_ready,
	input  wire logic [COORD_BITS-1:0] pt_x,
	input  wire logic [COORD_BITS-1:0] pt_y,
	input  wire logic [COORD_BITS-1:0] pt_z,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output logic [DIST_W-1:0]          distance,
	output logic [1:0]                 region,
	output logic                       degenerate
);
	localparam int C  = COORD_BITS;
	localparam int S  = 2 * C + 2;
	localparam int EW = 3 * S + TAG_W;

	logic [C-1:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
	logic         seg_mode_q;
	logic         wr_en;
	logic [2:0]   reg_idx;

	logic         front_en, back_en;
	logic         q_push, q_empty, q_full;
	logic [S-1:0] ent_a, ent_b, ent_c1;
	psd_tag_t     ent_tag, res_tag, head_tag;
	logic [EW-1:0] q_head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0x_q      <= '0;
			p0y_q      <= '0;
			p0z_q      <= '0;
			p1x_q      <= '0;
			p1y_q      <= '0;
			p1z_q      <= '0;
			seg_mode_q <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_X:  p0x_q <= pwdata[C-1:0];
				REG_START_Y:  p0y_q <= pwdata[C-1:0];
				REG_START_Z:  p0z_q <= pwdata[C-1:0];
				REG_END_X:    p1x_q <= pwdata[C-1:0];
				REG_END_Y:    p1y_q <= pwdata[C-1:0];
				REG_END_Z:    p1z_q <= pwdata[C-1:0];
				REG_SEG_MODE: seg_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		case (reg_idx)
			REG_START_X:  prdata = 32'(p0x_q);
			REG_START_Y:  prdata = 32'(p0y_q);
			REG_START_Z:  prdata = 32'(p0z_q);
			REG_END_X:    prdata = 32'(p1x_q);
			REG_END_Y:    prdata = 32'(p1y_q);
			REG_END_Z:    prdata = 32'(p1z_q);
			REG_SEG_MODE: prdata = 32'(seg_mode_q);
			default:      prdata = '0;
		endcase
	end

	// Front runs while the queue has room; back holds while a result waits
	assign front_en = !q_full;
	assign pt_ready = front_en;
	assign back_en  = !(res_valid && !res_ready);

	psd_front #(.C(C), .S(S)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (front_en),
		.pt_valid (pt_valid),
		.pt_x     (pt_x),
		.pt_y     (pt_y),
		.pt_z     (pt_z),
		.p0_x     (p0x_q),
		.p0_y     (p0y_q),
		.p0_z     (p0z_q),
		.p1_x     (p1x_q),
		.p1_y     (p1y_q),
		.p1_z     (p1z_q),
		.seg_mode (seg_mode_q),
		.push     (q_push),
		.ent_a    (ent_a),
		.ent_b    (ent_b),
		.ent_c1   (ent_c1),
		.ent_tag  (ent_tag)
	);

	psd_queue #(.W(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({ent_tag, ent_a, ent_b, ent_c1}),
		.pop       (back_en),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	assign head_tag = q_head[EW-1:3*S];

	psd_back #(.C(C), .F(FRAC_BITS), .S(S)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (back_en),
		.in_valid  (!q_empty),
		.in_a      (q_head[3*S-1:2*S]),
		.in_b      (q_head[2*S-1:S]),
		.in_c1     (q_head[S-1:0]),
		.in_tag    (head_tag),
		.out_valid (res_valid),
		.out_dist  (distance),
		.out_tag   (res_tag)
	);

	assign region     = res_tag.region;
	assign degenerate = res_tag.degen;

`include "point_line_segment_distance_assert.svh"

	`PSD_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
	`PSD_ASSERT_IMP(a_degen_from_start, res_valid && degenerate, region == REGION_START)
	`PSD_ASSERT_IMP(a_line_is_interior, res_valid && !seg_mode_q && !degenerate, region == REGION_INTERIOR)
	`PSD_ASSERT_NXT(a_full_blocks_input, q_full, !$past(pt_ready) || !$past(q_full) || pt_ready == !q_full)
endmodule
`default_nettype wire
